### hw/rtl/prpd_pkg.sv
// ----------------------------------------------------------------------------
// prpd_pkg
// shared types, constants and the nibble table of the packed run decoder
// ----------------------------------------------------------------------------
package prpd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam logic [7:0] RAW_INVERT = 8'hFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_PACKED = 2'd2
  } run_kind_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       packet_end;
  } result_t;

  // one request's results: first always present, second optional
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } nib_char_t;

  function automatic nib_char_t nibble_char(input logic [3:0] nib);
    nib_char_t r;
    r.valid = 1'b1;
    r.ch    = 8'h00;
    case (nib)
      4'd1:    r.ch = 8'h20;
      4'd2:    r.ch = 8'h2D;
      4'd3:    r.ch = 8'h2E;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13:
        r.ch = 8'h2C + {4'd0, nib};
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/prpd_front.sv
// ----------------------------------------------------------------------------
// prpd_front
// run state tracking and per-byte classification into result entries
// ----------------------------------------------------------------------------
module prpd_front
  import prpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       q_push,
  output q_entry_t   q_wdata
);

  run_kind_t  run_kind, run_kind_next;
  logic [6:0] chars_left, chars_left_next;

  nib_char_t hi, lo;
  logic      lo_used;
  logic      any;

  always_comb begin
    hi = nibble_char(in_byte[7:4]);
    lo = nibble_char(in_byte[3:0]);
    lo_used         = 1'b0;
    any             = 1'b0;
    q_wdata         = '0;
    run_kind_next   = run_kind;
    chars_left_next = chars_left;
    unique case (run_kind)
      KIND_RAW: begin
        any                 = 1'b1;
        q_wdata.r0.out_char = in_byte ^ RAW_INVERT;
        chars_left_next     = chars_left - 7'd1;
        run_kind_next       = (chars_left_next == 7'd0) ? KIND_HEADER : KIND_RAW;
      end
      KIND_PACKED: begin
        if (chars_left <= 7'd1) begin
          chars_left_next = 7'd0;
          run_kind_next   = KIND_HEADER;
        end else begin
          lo_used         = 1'b1;
          chars_left_next = chars_left - 7'd2;
          run_kind_next   = (chars_left_next == 7'd0) ? KIND_HEADER : KIND_PACKED;
        end
        // pack present characters so the first slot is always filled
        if (hi.valid) begin
          any                 = 1'b1;
          q_wdata.r0.out_char = hi.ch;
          q_wdata.two         = lo_used && lo.valid;
          q_wdata.r1.out_char = lo.ch;
        end else if (lo_used && lo.valid) begin
          any                 = 1'b1;
          q_wdata.r0.out_char = lo.ch;
        end
      end
      default: begin
        run_kind_next = KIND_HEADER;
        if (in_byte == END_BYTE) begin
          any                   = 1'b1;
          q_wdata.r0.packet_end = 1'b1;
        end else begin
          chars_left_next = in_byte[6:0];
          if (in_byte[6:0] != 7'd0) begin
            run_kind_next = in_byte[7] ? KIND_PACKED : KIND_RAW;
          end
        end
      end
    endcase
    q_push = accept && any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind   <= KIND_HEADER;
      chars_left <= 7'd0;
    end else if (accept) begin
      run_kind   <= run_kind_next;
      chars_left <= chars_left_next;
    end
  end

endmodule

### hw/rtl/prpd_queue.sv
// ----------------------------------------------------------------------------
// prpd_queue
// short queue of result entries between front and back
// ----------------------------------------------------------------------------
module prpd_queue
  import prpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_entry_t        mem [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign rdata        = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/prpd_back.sv
// ----------------------------------------------------------------------------
// prpd_back
// splits queued entries into single results and holds them in the output register
// ----------------------------------------------------------------------------
module prpd_back
  import prpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  q_rdata,
  input  q_status_t q_status,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output logic [7:0] out_char,
  output logic      packet_end
);

  logic    out_valid;
  result_t out_reg;
  logic    half;
  logic    load;

  assign empty      = !out_valid;
  assign out_char   = out_reg.out_char;
  assign packet_end = out_reg.packet_end;

  // output register frees up when empty or being taken
  assign load  = (!out_valid || pop) && !q_status.empty;
  assign q_pop = load && (half || !q_rdata.two);

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= half ? q_rdata.r1 : q_rdata.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        half      <= !half && q_rdata.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/packed_run_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// packed_run_packet_decoder_top
// decodes a packed/raw run byte stream into characters and packet end marks
// ----------------------------------------------------------------------------
// a byte that yields results is written into the queue when accepted, and its first
//   result then moves into the output register once that register is free
// throughput: one byte per cycle in while full is low, one result per cycle out
//   while pop is high; a two-character packed byte loads the output register twice
// full follows the queue fill between front and back (QDEPTH entries)
// reset (rst, synchronous) clears run state and empties the queue and output register
// ----------------------------------------------------------------------------
module packed_run_packet_decoder_top
  import prpd_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // request input side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  // result side
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       packet_end
);

  logic      accept;
  logic      q_push;
  logic      q_pop;
  q_entry_t  q_wdata;
  q_entry_t  q_rdata;
  q_status_t q_status;

  // a request enters whenever the queue has room
  assign full   = q_status.full;
  assign accept = push && !full;

  // front: run state and classification of each byte
  prpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decoupling queue, one entry per byte that yields results
  prpd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // back: one result per cycle into the output register while it is free or popped
  prpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rdata    (q_rdata),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_char   (out_char),
    .packet_end (packet_end)
  );

  // no write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue written while full");

  // no read from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  // end of packet carries no character
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && packet_end) |-> (out_char == 8'h00))
    else $error("packet end with nonzero character");

  // a waiting result is never dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(packet_end)))
    else $error("waiting result lost");

endmodule

### sim/prpd_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// prpd_scoreboard_pkg
// run decoder prediction and result checking for the decoder testbench
// ----------------------------------------------------------------------------
package prpd_scoreboard_pkg;
  import prpd_pkg::*;

  class prpd_scoreboard;
    run_kind_t  kind;
    logic [6:0] chars_owed;
    result_t    decoded_q[$];
    int         errors;

    function new();
      kind       = KIND_HEADER;
      chars_owed = 7'd0;
      errors     = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void add_char(input logic [7:0] ch);
      result_t r;
      r.out_char   = ch;
      r.packet_end = 1'b0;
      decoded_q = {decoded_q, r};
    endfunction

    // packed nibble codes; 0, 14 and 15 give no character
    function void add_nibble(input logic [3:0] nib);
      case (nib)
        4'd1: add_char(8'h20);
        4'd2: add_char(8'h2D);
        4'd3: add_char(8'h2E);
        4'd0, 4'd14, 4'd15: ;
        default: add_char(8'h30 + {4'd0, nib} - 8'd4);
      endcase
    endfunction

    function void note_request(input logic [7:0] b);
      result_t r;
      case (kind)
        KIND_RAW: begin
          add_char(b ^ RAW_INVERT);
          chars_owed = chars_owed - 7'd1;
          if (chars_owed == 7'd0) kind = KIND_HEADER;
        end
        KIND_PACKED: begin
          add_nibble(b[7:4]);
          if (chars_owed <= 7'd1) begin
            chars_owed = 7'd0;
            kind       = KIND_HEADER;
          end else begin
            add_nibble(b[3:0]);
            chars_owed = chars_owed - 7'd2;
            if (chars_owed == 7'd0) kind = KIND_HEADER;
          end
        end
        default: begin
          kind = KIND_HEADER;
          if (b == END_BYTE) begin
            r.out_char   = 8'h00;
            r.packet_end = 1'b1;
            decoded_q = {decoded_q, r};
          end else begin
            chars_owed = b[6:0];
            if (chars_owed != 7'd0) kind = b[7] ? KIND_PACKED : KIND_RAW;
          end
        end
      endcase
    endfunction

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(input logic [7:0] ch, input logic pe);
      result_t exp_r;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result char=%h end=%b", ch, pe));
      end else begin
        exp_r = decoded_q.pop_front();
        if (ch !== exp_r.out_char)
          report($sformatf("out_char %h, expected %h", ch, exp_r.out_char));
        if (pe !== exp_r.packet_end)
          report($sformatf("packet_end %b, expected %b", pe, exp_r.packet_end));
      end
    endtask
  endclass

endpackage

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives encoded byte streams into the packed run packet decoder with random
// gaps and stalls on both sides and checks every decoded character and
// packet end mark against a cycle-free prediction of the run decoder
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prpd_pkg::*;
  import prpd_scoreboard_pkg::*;

  // generous bound: every item's worst gaps and stalls, several times over
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1150;
  localparam int HOLD_AT     = 300;   // request count that starts the long hold-off
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       pop;
  logic       empty;
  logic [7:0] out_char;
  logic       packet_end;

  prpd_scoreboard sb;
  int  sent_count;
  int  cycle_count;
  int  rx_stall;
  bit  hold_off;

  // directed stream: end marks, empty headers, a raw run including all-ones data,
  // a packed run over every nibble code, and a packed run ending on an odd
  // character where the low nibble is dropped
  logic [7:0] directed_bytes [20] = '{
    8'hFF, 8'h00, 8'h80,
    8'h03, 8'h00, 8'hFF, 8'hA5,
    8'h90, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
    8'h83, 8'h4F, 8'h5E,
    8'hFF
  };

  packed_run_packet_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .pop        (pop),
    .empty      (empty),
    .out_char   (out_char),
    .packet_end (packet_end)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run bound
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long; some phases run flat out
  function automatic int pick_gap(input int phase);
    int r;
    if ((phase % 200) < 30) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one request: offered at the falling edge, taken at a rising edge with full low
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(b);
    sent_count++;
    gap = pick_gap(sent_count);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // mostly well-formed runs with random content, plus end marks, empty
  // headers and stray bytes that may open runs of their own
  task automatic send_random_stream(input int target);
    int         r;
    int         cnt;
    int         nbytes;
    logic [7:0] hdr;
    while (sent_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(END_BYTE);
      end else if (r < 12) begin
        send_byte($urandom_range(0, 1) ? 8'h80 : 8'h00);
      end else if (r < 90) begin
        r = $urandom_range(0, 49);
        if (r == 0) cnt = 127;
        else if (r < 4) cnt = $urandom_range(1, 127);
        else cnt = $urandom_range(1, 12);
        if ($urandom_range(0, 1)) begin
          // the longest packed header is 0xFE, since 0xFF is the end mark
          if (cnt == 127) cnt = 126;
          hdr    = 8'h80 | {1'b0, cnt[6:0]};
          nbytes = (cnt + 1) / 2;
        end else begin
          hdr    = {1'b0, cnt[6:0]};
          nbytes = cnt;
        end
        send_byte(hdr);
        repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // long receiver hold-off while the sender keeps going, so the queue fills
  initial begin
    hold_off = 1'b0;
    wait (sent_count >= HOLD_AT);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // result side: sample at the rising edge, decide pop at the falling edge
  initial begin
    rx_stall = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_result(out_char, packet_end);
        rx_stall = pick_gap(cycle_count / 7);
      end
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
      end else if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    sb          = new();
    sent_count  = 0;
    cycle_count = 0;
    rst         = 1'b1;
    push        = 1'b0;
    pop         = 1'b0;
    in_byte     = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_random_stream(ITEM_TARGET);

    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // let any stray result show up before the verdict
    repeat (10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/prpd_pkg.sv
hw/rtl/prpd_front.sv
hw/rtl/prpd_queue.sv
hw/rtl/prpd_back.sv
hw/rtl/packed_run_packet_decoder_top.sv
sim/prpd_scoreboard_pkg.sv
sim/tb_top.sv
